### hw/rtl/mos_pkg.sv
// Shared types and constants of the mask outline segment block.
// Used by the stream interfaces, the top level and the checker.
package mos_pkg;

   typedef logic [7:0]        alpha_type;
   typedef logic signed [7:0] coord_type;
   typedef logic [1:0]        csr_idx_type;
   typedef logic [6:0]        csr_data_type;

   localparam csr_idx_type CSR_MASK_WIDTH  = 2'd0;
   localparam csr_idx_type CSR_MASK_HEIGHT = 2'd1;
   localparam csr_idx_type CSR_CENTER_X    = 2'd2;
   localparam csr_idx_type CSR_CENTER_Y    = 2'd3;

   localparam int           RST_SIZE   = 17;
   localparam csr_data_type RST_CENTER = 7'd8;

   // Slots of the per-pixel segment group, in delivery order.
   localparam int SEG_LEFT   = 0;
   localparam int SEG_RIGHT  = 1;
   localparam int SEG_TOP    = 2;
   localparam int SEG_BOTTOM = 3;
   localparam int SEG_SLOTS  = 4;

endpackage

### hw/rtl/mos_req_if.sv
// Pixel stream interface: valid/ready handshake carrying one alpha value.
// Depends on mos_pkg.
interface mos_req_if;
   import mos_pkg::*;

   logic      valid;
   logic      ready;
   alpha_type alpha;

   modport source (output valid, output alpha, input ready);
   modport sink   (input valid, input alpha, output ready);
endinterface

### hw/rtl/mos_rsp_if.sv
// Segment stream interface: valid/ready handshake carrying one unit segment.
// Depends on mos_pkg.
interface mos_rsp_if;
   import mos_pkg::*;

   logic      valid;
   logic      ready;
   coord_type seg_x;
   coord_type seg_y;
   logic      vertical;
   logic      last;

   modport source (output valid, output seg_x, output seg_y, output vertical, output last,
                   input ready);
   modport sink   (input valid, input seg_x, input seg_y, input vertical, input last,
                   output ready);
endinterface

### hw/rtl/mask_outline_segments.sv
// Mask outline extraction: pixels in, unit boundary segments out.
// Depends on mos_pkg, mos_req_if and mos_rsp_if.
//
// Pixels arrive column by column, rows inner. Each accepted pixel is decoded
// into a group of up to four segments (left, right, top, bottom, in that order)
// held in a group register, which drains one segment per cycle into the result
// register while that register is empty or its beat is taken. A new pixel is
// taken only once the group has drained; its segments pass through the group
// register and then the result register. The previous column's opacity lives in
// a MAX_SIZE x 1 memory read one row ahead. Writing mask_width or mask_height
// restarts the scan at column 0, row 0.
module mask_outline_segments #(
   parameter int MAX_SIZE = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   mos_req_if.sink              req_bus,
   mos_rsp_if.source            rsp_bus,
   input  logic                 csr_we,
   input  mos_pkg::csr_idx_type csr_idx,
   input  mos_pkg::csr_data_type csr_wdata
);
   import mos_pkg::*;

   localparam int IDX_W    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int CMP_W    = (IDX_W + 1 > 7) ? IDX_W + 1 : 7;
   localparam int RST_EFF  = (RST_SIZE > MAX_SIZE) ? MAX_SIZE : RST_SIZE;
   localparam logic [IDX_W-1:0] RST_LAST = IDX_W'(RST_EFF - 1);

   typedef logic [IDX_W-1:0] idx_type;

   // configuration
   idx_type      last_col_ff, last_row_ff;
   csr_data_type center_x_ff, center_y_ff;
   logic         restart;

   // scan state
   idx_type col_idx_ff, col_idx_in;
   idx_type row_idx_ff, row_idx_in;
   logic    above_ff, above_in;

   // column memory with one-row-ahead read
   logic    col_mem [MAX_SIZE];
   logic    col_rd_ff;
   logic    byp_ff, byp_val_ff;
   logic    left_opaque;

   // segment group
   logic [SEG_SLOTS-1:0] pend_ff, pend_in, pend_new, pend_drained, sel_oh;
   logic [7:0]           grp_x_ff, grp_y_ff;

   // result register
   logic       rsp_valid_ff;
   logic [7:0] seg_x_ff, seg_y_ff;
   logic       vert_ff, last_ff;

   logic accept, load, opaque;

   function automatic idx_type size_to_last(input csr_data_type v);
      logic [CMP_W-1:0] v_ext;
      v_ext = CMP_W'(v);
      if (v_ext == '0) begin
         return '0;
      end else if (v_ext > CMP_W'(MAX_SIZE)) begin
         return IDX_W'(MAX_SIZE - 1);
      end else begin
         return IDX_W'(v_ext - CMP_W'(1));
      end
   endfunction

   assign restart = csr_we && (csr_idx == CSR_MASK_WIDTH || csr_idx == CSR_MASK_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= RST_LAST;
         last_row_ff <= RST_LAST;
         center_x_ff <= RST_CENTER;
         center_y_ff <= RST_CENTER;
      end else if (csr_we) begin
         unique case (csr_idx)
            CSR_MASK_WIDTH:  last_col_ff <= size_to_last(csr_wdata);
            CSR_MASK_HEIGHT: last_row_ff <= size_to_last(csr_wdata);
            CSR_CENTER_X:    center_x_ff <= csr_wdata;
            CSR_CENTER_Y:    center_y_ff <= csr_wdata;
         endcase
      end
   end

   assign opaque      = req_bus.alpha != '0;
   assign left_opaque = (col_idx_ff == '0) ? 1'b0 : (byp_ff ? byp_val_ff : col_rd_ff);

   // lowest pending slot goes out first
   assign sel_oh       = pend_ff & (~pend_ff + SEG_SLOTS'(1));
   assign load         = (pend_ff != '0) && (!rsp_valid_ff || rsp_bus.ready);
   assign pend_drained = load ? (pend_ff & ~sel_oh) : pend_ff;
   assign req_bus.ready = pend_drained == '0;
   assign accept       = req_bus.valid && req_bus.ready;

   always_comb begin
      pend_new             = '0;
      pend_new[SEG_LEFT]   = opaque != left_opaque;
      pend_new[SEG_RIGHT]  = opaque && (col_idx_ff == last_col_ff);
      pend_new[SEG_TOP]    = opaque != above_ff;
      pend_new[SEG_BOTTOM] = opaque && (row_idx_ff == last_row_ff);
      pend_in              = accept ? pend_new : pend_drained;
   end

   always_comb begin
      col_idx_in = col_idx_ff;
      row_idx_in = row_idx_ff;
      above_in   = above_ff;
      if (restart) begin
         col_idx_in = '0;
         row_idx_in = '0;
         above_in   = 1'b0;
      end else if (accept) begin
         above_in = opaque;
         if (row_idx_ff == last_row_ff) begin
            row_idx_in = '0;
            above_in   = 1'b0;
            col_idx_in = (col_idx_ff == last_col_ff) ? '0 : col_idx_ff + IDX_W'(1);
         end else begin
            row_idx_in = row_idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_idx_ff <= '0;
         row_idx_ff <= '0;
         above_ff   <= 1'b0;
         pend_ff    <= '0;
         byp_ff     <= 1'b0;
      end else begin
         col_idx_ff <= col_idx_in;
         row_idx_ff <= row_idx_in;
         above_ff   <= above_in;
         pend_ff    <= pend_in;
         // forward a write to the row being fetched
         byp_ff     <= accept && (row_idx_in == row_idx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         col_mem[row_idx_ff] <= opaque;
      end
      col_rd_ff  <= col_mem[row_idx_in];
      byp_val_ff <= opaque;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         grp_x_ff <= 8'(col_idx_ff) - 8'(center_x_ff);
         grp_y_ff <= 8'(row_idx_ff) - 8'(center_y_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         seg_x_ff <= grp_x_ff + {7'd0, sel_oh[SEG_RIGHT]};
         seg_y_ff <= grp_y_ff + {7'd0, sel_oh[SEG_BOTTOM]};
         vert_ff  <= sel_oh[SEG_LEFT] | sel_oh[SEG_RIGHT];
         last_ff  <= (pend_ff & ~sel_oh) == '0;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.seg_x    = seg_x_ff;
   assign rsp_bus.seg_y    = seg_y_ff;
   assign rsp_bus.vertical = vert_ff;
   assign rsp_bus.last     = last_ff;

endmodule

### hw/rtl/mos_check.sv
// Port-level checks for mask_outline_segments, attached by bind.
// Depends on mos_pkg and the top level's ports.
module mos_check (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last
);
   import mos_pkg::*;

   // a segment beat once shown stays until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // more segments of this pixel wait behind a stalled beat: hold the input
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && !rsp_last |-> !req_ready)
      else $error("pixel taken while its group is incomplete");

   // the rest of a pixel's group follows without a gap
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside a segment group");

endmodule

bind mask_outline_segments mos_check u_mos_check (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_last  (rsp_bus.last)
);

### test/mask_outline_segments_checker.sv
// Scoreboard for mask_outline_segments: tracks the scan position and the previous
// column's opacity, predicts the outline segments of each pixel beat and checks them.
// Depends on mos_pkg, mos_req_if and mos_rsp_if.
module mask_outline_segments_checker #(
   parameter int MAX_SIZE = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   mos_req_if                    req_bus,
   mos_rsp_if                    rsp_bus,
   input  logic                  csr_we,
   input  mos_pkg::csr_idx_type  csr_idx,
   input  mos_pkg::csr_data_type csr_wdata,
   output int                    mismatches,
   output int                    segs_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import mos_pkg::*;

   typedef struct packed {
      coord_type seg_x;
      coord_type seg_y;
      logic      vertical;
      logic      last;
   } outline_seg_type;

   outline_seg_type     segs_due[$];
   logic [MAX_SIZE-1:0] prev_col_opaque;
   int unsigned         scan_col;
   int unsigned         scan_row;
   logic                above_opaque;
   csr_data_type        width_reg;
   csr_data_type        height_reg;
   csr_data_type        cx_reg;
   csr_data_type        cy_reg;

   function automatic int unsigned clamp_size(input csr_data_type v);
      if (v == 0) begin
         return 1;
      end
      if (v > MAX_SIZE) begin
         return MAX_SIZE;
      end
      return int'(v);
   endfunction

   function automatic outline_seg_type make_seg(input int unsigned x, input int unsigned y,
                                                input logic vert);
      outline_seg_type s;
      s.seg_x    = coord_type'(int'(x) - int'(cx_reg));
      s.seg_y    = coord_type'(int'(y) - int'(cy_reg));
      s.vertical = vert;
      s.last     = 1'b0;
      return s;
   endfunction

   task automatic trace_pixel(input alpha_type a);
      outline_seg_type grp[SEG_SLOTS];
      int              n;
      int unsigned     w;
      int unsigned     h;
      int unsigned     i;
      int unsigned     j;
      logic            opaque;
      logic            left_opaque;
      n = 0;
      w = clamp_size(width_reg);
      h = clamp_size(height_reg);
      i = (scan_col >= w) ? w - 1 : scan_col;
      j = (scan_row >= h) ? h - 1 : scan_row;
      opaque = (a != 0);
      left_opaque = (i == 0) ? 1'b0 : prev_col_opaque[j];

      if (opaque != left_opaque) begin
         grp[n] = make_seg(i, j, 1'b1);
         n++;
      end
      if (opaque && i + 1 >= w) begin
         grp[n] = make_seg(i + 1, j, 1'b1);
         n++;
      end
      if ((j == 0) ? opaque : (opaque != above_opaque)) begin
         grp[n] = make_seg(i, j, 1'b0);
         n++;
      end
      if (opaque && j + 1 >= h) begin
         grp[n] = make_seg(i, j + 1, 1'b0);
         n++;
      end
      for (int k = 0; k < n; k++) begin
         grp[k].last = (k == n - 1);
         segs_due.insert(segs_due.size(), grp[k]);
      end

      prev_col_opaque[j] = opaque;
      above_opaque = opaque;
      if (j + 1 >= h) begin
         scan_row = 0;
         above_opaque = 1'b0;
         scan_col = (i + 1 >= w) ? 0 : i + 1;
      end else begin
         scan_row = j + 1;
         scan_col = i;
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("%0t ns: segment mismatch: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      outline_seg_type want;
      if (reset) begin
         segs_due.delete();
         prev_col_opaque = '0;
         scan_col = 0;
         scan_row = 0;
         above_opaque = 1'b0;
         width_reg = csr_data_type'(RST_SIZE);
         height_reg = csr_data_type'(RST_SIZE);
         cx_reg = RST_CENTER;
         cy_reg = RST_CENTER;
      end else begin
         if (csr_we) begin
            case (csr_idx)
               CSR_MASK_WIDTH: begin
                  width_reg = csr_wdata;
                  scan_col = 0;
                  scan_row = 0;
                  above_opaque = 1'b0;
               end
               CSR_MASK_HEIGHT: begin
                  height_reg = csr_wdata;
                  scan_col = 0;
                  scan_row = 0;
                  above_opaque = 1'b0;
               end
               CSR_CENTER_X: begin
                  cx_reg = csr_wdata;
               end
               CSR_CENTER_Y: begin
                  cy_reg = csr_wdata;
               end
               default: begin
               end
            endcase
         end
         // queue the new pixel's segments before popping: a beat can never answer itself
         if (req_bus.valid && req_bus.ready) begin
            trace_pixel(req_bus.alpha);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (segs_due.size() == 0) begin
               report_mismatch($sformatf("unexpected beat x=%0d y=%0d vertical=%0b last=%0b",
                                         rsp_bus.seg_x, rsp_bus.seg_y, rsp_bus.vertical,
                                         rsp_bus.last));
            end else begin
               want = segs_due.pop_front();
               if (rsp_bus.seg_x !== want.seg_x) begin
                  report_mismatch($sformatf("seg_x got %0d want %0d",
                                            rsp_bus.seg_x, want.seg_x));
               end
               if (rsp_bus.seg_y !== want.seg_y) begin
                  report_mismatch($sformatf("seg_y got %0d want %0d",
                                            rsp_bus.seg_y, want.seg_y));
               end
               if (rsp_bus.vertical !== want.vertical) begin
                  report_mismatch($sformatf("vertical got %0b want %0b",
                                            rsp_bus.vertical, want.vertical));
               end
               if (rsp_bus.last !== want.last) begin
                  report_mismatch($sformatf("last got %0b want %0b",
                                            rsp_bus.last, want.last));
               end
            end
         end
      end
      segs_pending = segs_due.size();
   end

endmodule

### test/mask_outline_segments_test.sv
// Top of the mask_outline_segments testbench: clock, reset, register writes, pixel
// stimulus and receiver stalls; checking lives in mask_outline_segments_checker.
// Depends on mos_pkg, mos_req_if, mos_rsp_if and the checker.
module mask_outline_segments_test;
   timeunit 1ns;
   timeprecision 1ps;
   import mos_pkg::*;

   logic         clock = 1'b0;
   logic         reset;
   logic         csr_we;
   csr_idx_type  csr_idx;
   csr_data_type csr_wdata;
   int           mismatches;
   int           segs_pending;
   int           send_idle_pct;
   int           recv_idle_pct;
   int           rsp_hold;

   alpha_type    column_probe[8] = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd0, 8'd127, 8'd254, 8'd0};
   alpha_type    lone_pixels[3]  = '{8'd255, 8'd0, 8'd1};
   alpha_type    cross_shape[9]  = '{8'd0, 8'd255, 8'd0, 8'd64, 8'd2, 8'd16, 8'd0, 8'd32, 8'd0};

   mos_req_if req_bus ();
   mos_rsp_if rsp_bus ();

   mask_outline_segments dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   mask_outline_segments_checker checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_we       (csr_we),
      .csr_idx      (csr_idx),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .segs_pending (segs_pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver: a long hold-off takes priority over the random stall
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_pixel(input alpha_type a);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.alpha <= a;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic send_random(input int count, input int zero_pct);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(99) < zero_pct) begin
            send_pixel(8'd0);
         end else begin
            send_pixel(alpha_type'($urandom_range(255)));
         end
      end
   endtask

   // drop valid, wait for every segment, then let the block idle
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (segs_pending != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
   endtask

   task automatic configure(input int w, input int h, input int cx, input int cy);
      csr_we <= 1'b1;
      csr_idx <= CSR_MASK_WIDTH;
      csr_wdata <= csr_data_type'(w);
      @(negedge clock);
      csr_idx <= CSR_MASK_HEIGHT;
      csr_wdata <= csr_data_type'(h);
      @(negedge clock);
      csr_idx <= CSR_CENTER_X;
      csr_wdata <= csr_data_type'(cx);
      @(negedge clock);
      csr_idx <= CSR_CENTER_Y;
      csr_wdata <= csr_data_type'(cy);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_idx = CSR_MASK_WIDTH;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.alpha = '0;
      rsp_bus.ready = 1'b0;
      rsp_hold = 0;
      send_idle_pct = 30;
      recv_idle_pct = 55;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset geometry: part of the first column
      foreach (column_probe[k]) begin
         send_pixel(column_probe[k]);
      end
      settle();
      // zero sizes act as a single-pixel mask
      configure(0, 0, 0, 0);
      foreach (lone_pixels[k]) begin
         send_pixel(lone_pixels[k]);
      end
      settle();
      configure(3, 3, 1, 1);
      foreach (cross_shape[k]) begin
         send_pixel(cross_shape[k]);
      end
      settle();

      configure(5, 4, 2, 1);
      send_random(20, 40);
      settle();
      configure(1, 64, 0, 64);
      send_random(64, 30);
      settle();

      send_idle_pct = 55;
      recv_idle_pct = 30;
      configure(127, 1, 127, 0);
      send_random(64, 50);
      settle();
      configure(3, 3, 127, 127);
      send_random(18, 40);
      settle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure(2, 127, 64, 32);
      // hold the result side long enough to back the block up into its input
      rsp_hold = 150;
      send_random(74, 35);
      settle();

      if (mismatches == 0 && segs_pending == 0) begin
         $display("mask_outline_segments_test passed");
      end else begin
         $display("mask_outline_segments_test failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("mask_outline_segments_test failed");
      $finish;
   end

endmodule
